// ===== rtl/aou_pkg.sv =====
// Package for the angular occlusion union unit.
// Holds the sine and arctangent tables, the sequencer states and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
package aou_pkg;

    localparam int MAX_RECTS_DEF       = 64;
    localparam int CORDIC_ITERS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_CINIT, ST_CITER, ST_CFIN, ST_INSERT, ST_MERGE, ST_FINISH
    } state_t;

    typedef struct packed {
        logic ins;
        logic shl;
    } cell_ctrl_t;

    localparam logic [14:0] SINE_Q14 [0:90] = '{
        15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
        15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
        15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
        15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
        15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
        15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11983, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
        15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
        15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
        15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
        15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    localparam logic [21:0] ATAN_Q16 [0:23] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
        22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2,
        22'd1, 22'd0
    };

    // Sine in Q1.14 for a whole-degree angle already reduced to 0..359.
    function automatic logic signed [15:0] sin_deg(input logic [8:0] r);
        logic [8:0] k;
        logic       neg;
        begin
            neg = 1'b0;
            if (r <= 9'd90) begin
                k = r;
            end else if (r <= 9'd180) begin
                k = 9'd180 - r;
            end else if (r <= 9'd270) begin
                k = r - 9'd180;
                neg = 1'b1;
            end else begin
                k = 9'd360 - r;
                neg = 1'b1;
            end
            sin_deg = neg ? -$signed({1'b0, SINE_Q14[k[6:0]]})
                          : $signed({1'b0, SINE_Q14[k[6:0]]});
        end
    endfunction

endpackage

// ===== rtl/aou_cell.sv =====
// One slot of the sorted interval row: holds one (start, end) pair.
// Inserts in order against its left neighbor, or shifts toward slot 0 for the merge.
// Depends on aou_pkg.
`timescale 1ns / 1ps
module aou_cell #(
    parameter int BW  = 17,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic                aclk,
    input  aou_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       count,
    input  logic [BW-1:0]       new_lo,
    input  logic [BW-1:0]       new_hi,
    input  logic [BW-1:0]       prev_lo,
    input  logic [BW-1:0]       prev_hi,
    input  logic [BW-1:0]       next_lo,
    input  logic [BW-1:0]       next_hi,
    output logic [BW-1:0]       lo,
    output logic [BW-1:0]       hi
);

    logic [BW-1:0] lo_reg, hi_reg, lo_next, hi_next;
    logic below, at_end, self_gt, prev_gt;

    assign below   = CW'(IDX) < count;
    assign at_end  = CW'(IDX) == count;
    assign self_gt = lo_reg > new_lo;
    assign prev_gt = (IDX > 0) && (prev_lo > new_lo);

    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.shl) begin
            lo_next = next_lo;
            hi_next = next_hi;
        end else if (ctrl.ins && ((below && self_gt) || at_end)) begin
            // A larger start to the left moves right; otherwise the new pair lands here.
            lo_next = prev_gt ? prev_lo : new_lo;
            hi_next = prev_gt ? prev_hi : new_hi;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

// ===== rtl/angular_occlusion_union_unit.sv =====
// Sequence: the multiplier forms w*cos, w*sin, h*cos and h*sin; each corner then runs CORDIC init,
// the CORDIC iterations (skipped on the x axis) and a finish step; an insert step follows.
// A last rectangle then merges the row and finishes; requests are taken only in the idle state.
// The next request is taken while a result waits; a second last rectangle stalls until it leaves.
// Reset: aresetn, synchronous, active low, clears the sequencer, count, overflow flag and output valid.
// Top level of the angular occlusion union unit; uses aou_pkg and aou_cell.
`timescale 1ns / 1ps
module angular_occlusion_union_unit #(
    parameter int MAX_RECTS       = aou_pkg::MAX_RECTS_DEF,
    parameter int CORDIC_ITERS    = aou_pkg::CORDIC_ITERS_DEF,
    parameter int ANGLE_FRAC_BITS = aou_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // center_x[11:0], center_y[23:12], rect_width[35:24], rect_height[47:36],
    // rotation_deg[56:48], zero fill above
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // total_angle[16:0], rect_count[23:17], overflow[24], zero fill above
    output logic [31:0] m_tdata
);

    localparam int BW   = 9 + ANGLE_FRAC_BITS;
    localparam int CW   = $clog2(MAX_RECTS + 1);
    localparam int IW   = $clog2(CORDIC_ITERS);
    localparam int XW   = 33;
    localparam int ZW   = 27;
    localparam int PW   = 29;
    localparam int SH   = 16 - ANGLE_FRAC_BITS;
    localparam int RND  = (SH > 0) ? (1 << (SH - 1)) : 0;
    localparam int TW   = BW + 1;
    localparam logic signed [ZW-1:0] Z_FULL = ZW'(360 * 65536);
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(180 * 65536);
    localparam logic [TW-1:0] Q_FULL = TW'(360 << ANGLE_FRAC_BITS);

    aou_pkg::state_t state_reg, state_next;

    logic signed [11:0] cx_reg, cy_reg;
    logic [11:0]        w_reg, h_reg;
    logic [8:0]         rot_reg;
    logic               last_reg;
    logic signed [PW-1:0] wc_reg, ws_reg, hc_reg, hs_reg;
    logic [1:0]         step_reg;   // multiplier step, then corner index
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [IW-1:0]      it_reg;
    logic [BW-1:0]      blo_reg, bhi_reg;
    logic [CW-1:0]      cnt_reg, midx_reg;
    logic               drop_reg;
    logic [BW-1:0]      run_lo_reg, run_hi_reg;
    logic [TW-1:0]      total_reg;
    logic               m_valid_reg;
    logic [16:0]        out_total_reg;
    logic [6:0]         out_count_reg;
    logic               out_ovf_reg;

    // Rotation, sine and cosine.
    logic [8:0]  rot_m, cos_arg;
    logic [9:0]  cos_sum;
    logic signed [15:0] sin_v, cos_v, mul_b;
    logic signed [12:0] mul_a;
    logic signed [PW-1:0] prod;

    assign rot_m   = (rot_reg >= 9'd360) ? rot_reg - 9'd360 : rot_reg;
    assign cos_sum = {1'b0, rot_m} + 10'd90;
    assign cos_arg = (cos_sum >= 10'd360) ? 9'(cos_sum - 10'd360) : cos_sum[8:0];
    assign sin_v   = aou_pkg::sin_deg(rot_m);
    assign cos_v   = aou_pkg::sin_deg(cos_arg);
    assign mul_a   = step_reg[1] ? $signed({1'b0, h_reg}) : $signed({1'b0, w_reg});
    assign mul_b   = step_reg[0] ? sin_v : cos_v;
    assign prod    = PW'(mul_a * mul_b);

    // Corner coordinates in doubled units scaled by 2^14.
    logic sx_neg, sy_neg;
    logic signed [XW-1:0] cx2, cy2, cx_term, cy_term;
    assign sx_neg = (step_reg == 2'd0) || (step_reg == 2'd3);
    assign sy_neg = (step_reg == 2'd0) || (step_reg == 2'd1);
    assign cx2 = XW'(cx_reg) <<< 15;
    assign cy2 = XW'(cy_reg) <<< 15;
    assign cx_term = cx2 + (sx_neg ? -XW'(wc_reg) : XW'(wc_reg))
                         - (sy_neg ? -XW'(hs_reg) : XW'(hs_reg));
    assign cy_term = cy2 + (sx_neg ? -XW'(ws_reg) : XW'(ws_reg))
                         + (sy_neg ? -XW'(hc_reg) : XW'(hc_reg));

    // One CORDIC vectoring step.
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] atan_v;
    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign atan_v = ZW'($signed({1'b0, aou_pkg::ATAN_Q16[5'(it_reg)]}));

    // Bearing normalization and rounding.
    logic signed [ZW-1:0] z_norm;
    logic [TW-1:0] q_raw, q_wrap;
    logic [BW-1:0] bear;
    always_comb begin
        z_norm = z_reg;
        if (z_reg < 0) begin
            z_norm = z_reg + Z_FULL;
        end else if (z_reg >= Z_FULL) begin
            z_norm = z_reg - Z_FULL;
        end
    end
    assign q_raw  = TW'((ZW'(z_norm) + ZW'(RND)) >>> SH);
    assign q_wrap = (q_raw >= Q_FULL) ? q_raw - Q_FULL : q_raw;
    assign bear   = q_wrap[BW-1:0];

    // Interval row.
    aou_pkg::cell_ctrl_t ctrl;
    logic [BW-1:0] lo_arr [0:MAX_RECTS];
    logic [BW-1:0] hi_arr [0:MAX_RECTS];
    assign lo_arr[MAX_RECTS] = '0;
    assign hi_arr[MAX_RECTS] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_RECTS; g++) begin : g_cell
            aou_cell #(.BW(BW), .CW(CW), .IDX(g)) u_cell (
                .aclk    (aclk),
                .ctrl    (ctrl),
                .count   (cnt_reg),
                .new_lo  (blo_reg),
                .new_hi  (bhi_reg),
                .prev_lo (lo_arr[(g > 0) ? g - 1 : 0]),
                .prev_hi (hi_arr[(g > 0) ? g - 1 : 0]),
                .next_lo (lo_arr[g + 1]),
                .next_hi (hi_arr[g + 1]),
                .lo      (lo_arr[g]),
                .hi      (hi_arr[g])
            );
        end
    endgenerate

    logic full, out_free, accept;
    assign full     = cnt_reg == CW'(MAX_RECTS);
    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            aou_pkg::ST_IDLE:   if (s_tvalid) state_next = aou_pkg::ST_MUL;
            aou_pkg::ST_MUL:    if (step_reg == 2'd3) state_next = aou_pkg::ST_CINIT;
            aou_pkg::ST_CINIT:  state_next = (cy_term == 0) ? aou_pkg::ST_CFIN
                                                            : aou_pkg::ST_CITER;
            aou_pkg::ST_CITER:  if (it_reg == IW'(CORDIC_ITERS - 1)) begin
                state_next = aou_pkg::ST_CFIN;
            end
            aou_pkg::ST_CFIN:   state_next = (step_reg == 2'd3) ? aou_pkg::ST_INSERT
                                                                : aou_pkg::ST_CINIT;
            aou_pkg::ST_INSERT: state_next = last_reg ? aou_pkg::ST_MERGE : aou_pkg::ST_IDLE;
            aou_pkg::ST_MERGE:  if (midx_reg == cnt_reg - CW'(1)) begin
                state_next = aou_pkg::ST_FINISH;
            end
            aou_pkg::ST_FINISH: if (out_free) state_next = aou_pkg::ST_IDLE;
            default:            state_next = aou_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready = 1'b0;
        ctrl     = '0;
        unique case (state_reg)
            aou_pkg::ST_IDLE:   s_tready = 1'b1;
            aou_pkg::ST_INSERT: ctrl.ins = !full;
            aou_pkg::ST_MERGE:  ctrl.shl = 1'b1;
            default:            ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aou_pkg::ST_IDLE;
            cnt_reg     <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == aou_pkg::ST_INSERT) begin
                if (full) drop_reg <= 1'b1;
                else      cnt_reg  <= cnt_reg + CW'(1);
            end
            if (state_reg == aou_pkg::ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
                cnt_reg     <= '0;
                drop_reg    <= 1'b0;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            aou_pkg::ST_IDLE: begin
                cx_reg   <= s_tdata[11:0];
                cy_reg   <= s_tdata[23:12];
                w_reg    <= s_tdata[35:24];
                h_reg    <= s_tdata[47:36];
                rot_reg  <= s_tdata[56:48];
                last_reg <= s_tlast;
                step_reg <= '0;
            end
            aou_pkg::ST_MUL: begin
                unique case (step_reg)
                    2'd0:    wc_reg <= prod;
                    2'd1:    ws_reg <= prod;
                    2'd2:    hc_reg <= prod;
                    default: hs_reg <= prod;
                endcase
                step_reg <= step_reg + 2'd1;
            end
            aou_pkg::ST_CINIT: begin
                it_reg <= '0;
                if (cy_term == 0) begin
                    z_reg <= (cx_term < 0) ? Z_HALF : '0;
                end else if (cx_term < 0) begin
                    x_reg <= -cx_term;
                    y_reg <= -cy_term;
                    z_reg <= Z_HALF;
                end else begin
                    x_reg <= cx_term;
                    y_reg <= cy_term;
                    z_reg <= '0;
                end
            end
            aou_pkg::ST_CITER: begin
                if (y_reg >= 0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_v;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_v;
                end
                it_reg <= it_reg + IW'(1);
            end
            aou_pkg::ST_CFIN: begin
                if (step_reg == 2'd0 || bear < blo_reg) blo_reg <= bear;
                if (step_reg == 2'd0 || bear > bhi_reg) bhi_reg <= bear;
                step_reg <= step_reg + 2'd1;
            end
            aou_pkg::ST_INSERT: begin
                midx_reg  <= '0;
                total_reg <= '0;
            end
            aou_pkg::ST_MERGE: begin
                // Slot 0 presents the next interval in start order each cycle.
                if (midx_reg == '0 || lo_arr[0] > run_hi_reg) begin
                    if (midx_reg != '0) total_reg <= total_reg + TW'(run_hi_reg - run_lo_reg);
                    run_lo_reg <= lo_arr[0];
                    run_hi_reg <= hi_arr[0];
                end else if (hi_arr[0] > run_hi_reg) begin
                    run_hi_reg <= hi_arr[0];
                end
                midx_reg <= midx_reg + CW'(1);
            end
            aou_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_total_reg <= 17'(total_reg + TW'(run_hi_reg - run_lo_reg));
                    out_count_reg <= 7'(cnt_reg);
                    out_ovf_reg   <= drop_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_ovf_reg, out_count_reg, out_total_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_RECTS)) else $error("interval count above capacity");
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == aou_pkg::ST_INSERT && !full) |=> !$rose(drop_reg))
        else $error("overflow raised while room remained");
    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == aou_pkg::ST_MUL) else $error("accepted request not started");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == aou_pkg::ST_FINISH && out_free) |=> (m_tvalid && cnt_reg == '0))
        else $error("result not presented after merge");

endmodule
